// ===== src/image_filter_3x3_macros.svh =====
// Assertion macros shared by the image filter modules.
`ifndef IMAGE_FILTER_3X3_MACROS_SVH
`define IMAGE_FILTER_3X3_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define IF3_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Condition that must never hold outside reset.
`define IF3_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");

`endif

// ===== src/if3_pkg.sv =====
// ----------------------------------------------------------------------------
// if3_pkg
// Types, constants and helpers shared by the 3x3 image filter.
// ----------------------------------------------------------------------------
package if3_pkg;

    localparam int MaxWidth  = 1024;
    localparam int AddrW     = $clog2(MaxWidth);
    localparam int QueueDepth = 4;
    localparam int QueueAw   = $clog2(QueueDepth);

    localparam logic [2:0] MODE_AVG   = 3'd0;
    localparam logic [2:0] MODE_SHARP = 3'd1;
    localparam logic [2:0] MODE_SOBX  = 3'd2;
    localparam logic [2:0] MODE_SOBY  = 3'd3;
    localparam logic [2:0] MODE_MAG   = 3'd4;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_GAIN   = 2'd1;
    localparam logic [1:0] REG_WIDTH  = 2'd2;
    localparam logic [1:0] REG_HEIGHT = 2'd3;

    // One complete neighbourhood, passed from front to back.
    typedef struct packed {
        logic [8:0][7:0] p;      // row-major, p[3*r+c]
        logic [11:0]     row;
        logic [9:0]      col;
        logic            last;
    } window_t;

endpackage

// ===== src/if3_ram.sv =====
// ----------------------------------------------------------------------------
// if3_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module if3_ram #(
    parameter int Width = 8,
    parameter int Depth = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/if3_front.sv =====
// ----------------------------------------------------------------------------
// if3_front
// Raster counters, line buffers and the window: builds each neighbourhood.
// ----------------------------------------------------------------------------
`include "image_filter_3x3_macros.svh"

module if3_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           pixel,
    input  logic                 frame_start,
    input  logic                 valid,
    output logic                 ready,
    input  logic [10:0]          image_width,
    input  logic [11:0]          image_height,
    output logic                 win_valid,
    output if3_pkg::window_t     win,
    input  logic                 win_ready
);

    typedef enum logic [1:0] { S_IDLE, S_READ, S_EMIT } state_t;

    state_t                     state_reg;
    logic [7:0]                 pix_reg;
    logic [9:0]                 col_reg;
    logic [11:0]                row_reg;
    logic [9:0]                 cur_col_reg;
    logic [11:0]                cur_row_reg;
    logic [5:0][7:0]            wc_reg;
    logic                       win_valid_reg;
    if3_pkg::window_t           win_reg;
    logic [7:0]                 top_q;
    logic [7:0]                 mid_q;
    logic [10:0]                w_eff;
    logic [11:0]                h_eff;
    logic [9:0]                 col_in;
    logic [11:0]                row_in;
    logic                       accept;
    logic                       do_write;
    logic                       emit;
    logic [10:0]                col_p1;
    logic [12:0]                row_p1;

    // Effective geometry after clamping.
    always_comb
    begin
        if (image_width < 11'd3)
        begin
            w_eff = 11'd3;
        end
        else if (image_width > 11'(if3_pkg::MaxWidth))
        begin
            w_eff = 11'(if3_pkg::MaxWidth);
        end
        else
        begin
            w_eff = image_width;
        end
        h_eff = (image_height < 12'd3) ? 12'd3 : image_height;
    end

    assign ready  = (state_reg == S_IDLE);
    assign accept = valid && ready;
    assign col_in = frame_start ? 10'd0 : col_reg;
    assign row_in = frame_start ? 12'd0 : row_reg;
    assign col_p1 = {1'b0, cur_col_reg} + 11'd1;
    assign row_p1 = {1'b0, cur_row_reg} + 13'd1;
    assign emit   = (cur_row_reg >= 12'd2) && (cur_col_reg >= 10'd2);
    assign do_write = (state_reg == S_READ);

    // Line buffers: read at accept, written back in the following cycle.
    if3_ram #(.Width(8), .Depth(if3_pkg::MaxWidth)) u_line_two (
        .clk   (clk),
        .we    (do_write),
        .waddr (cur_col_reg),
        .wdata (mid_q),
        .re    (accept),
        .raddr (col_in),
        .rdata (top_q)
    );

    if3_ram #(.Width(8), .Depth(if3_pkg::MaxWidth)) u_line_one (
        .clk   (clk),
        .we    (do_write),
        .waddr (cur_col_reg),
        .wdata (pix_reg),
        .re    (accept),
        .raddr (col_in),
        .rdata (mid_q)
    );

    // Sequencer, counters, window and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            wc_reg        <= '0;
            win_valid_reg <= 1'b0;
            pix_reg       <= '0;
            win_reg       <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        pix_reg     <= pixel;
                        cur_col_reg <= col_in;
                        cur_row_reg <= row_in;
                        state_reg   <= S_READ;
                    end
                end
                S_READ:
                begin
                    win_reg.p   <= {pix_reg, wc_reg[2], wc_reg[5], mid_q, wc_reg[1],
                                    wc_reg[4], top_q, wc_reg[0], wc_reg[3]};
                    win_reg.row <= cur_row_reg - 12'd1;
                    win_reg.col <= cur_col_reg - 10'd1;
                    win_reg.last <= (row_p1 >= {1'b0, h_eff}) && (col_p1 >= w_eff);
                    wc_reg      <= {wc_reg[2:0], pix_reg, mid_q, top_q};
                    if (col_p1 >= w_eff)
                    begin
                        col_reg <= '0;
                        row_reg <= (row_p1 >= {1'b0, h_eff}) ? 12'd0 : row_p1[11:0];
                    end
                    else
                    begin
                        col_reg <= col_p1[9:0];
                        row_reg <= cur_row_reg;
                    end
                    if (emit)
                    begin
                        win_valid_reg <= 1'b1;
                        state_reg     <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_EMIT:
                begin
                    if (win_ready)
                    begin
                        win_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign win_valid = win_valid_reg;
    assign win       = win_reg;

    `IF3_ASSERT_IMPL(a_emit_state, clk, rst_n, win_valid_reg, state_reg == S_EMIT)
    `IF3_ASSERT_IMPL(a_win_interior, clk, rst_n, win_valid_reg, win_reg.col != 10'd0)
    `IF3_ASSERT_NEVER(a_accept_busy, clk, rst_n, accept && (state_reg != S_IDLE))

endmodule

// ===== src/if3_queue.sv =====
// ----------------------------------------------------------------------------
// if3_queue
// Short queue of neighbourhoods between the front and the back.
// ----------------------------------------------------------------------------
`include "image_filter_3x3_macros.svh"

module if3_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  if3_pkg::window_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output if3_pkg::window_t out_data
);

    if3_pkg::window_t                 slot_reg [if3_pkg::QueueDepth];
    logic [if3_pkg::QueueAw-1:0]      wr_reg;
    logic [if3_pkg::QueueAw-1:0]      rd_reg;
    logic [if3_pkg::QueueAw:0]        cnt_reg;
    logic                             push;
    logic                             pop;

    assign in_ready  = (cnt_reg != (if3_pkg::QueueAw+1)'(if3_pkg::QueueDepth));
    assign out_valid = (cnt_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = slot_reg[rd_reg];

    // Storage slots.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= in_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    `IF3_ASSERT_NEVER(a_q_over, clk, rst_n,
        cnt_reg > (if3_pkg::QueueAw+1)'(if3_pkg::QueueDepth))
    `IF3_ASSERT_IMPL(a_q_ptr, clk, rst_n, cnt_reg == '0, wr_reg == rd_reg)

endmodule

// ===== src/if3_back.sv =====
// ----------------------------------------------------------------------------
// if3_back
// Filter arithmetic: one neighbourhood in, one rounded pixel out.
// ----------------------------------------------------------------------------
`include "image_filter_3x3_macros.svh"

module if3_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  if3_pkg::window_t in_data,
    input  logic [2:0]       mode,
    input  logic [8:0]       sharpen_gain,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       value,
    output logic [11:0]      out_row,
    output logic [9:0]       out_col,
    output logic             last
);

    typedef enum logic [2:0] { S_IDLE, S_MUL, S_ADD, S_SQRT, S_RES, S_OUT } state_t;

    state_t            state_reg;
    if3_pkg::window_t  w_reg;
    logic signed [11:0] gx_reg;
    logic signed [11:0] gy_reg;
    logic signed [12:0] avg_reg;
    logic signed [11:0] lap_reg;
    logic signed [22:0] prod_reg;
    logic [21:0]       sq_x_reg;
    logic [21:0]       sq_y_reg;
    logic [28:0]       rem_reg;
    logic [14:0]       root_reg;
    logic [3:0]        step_reg;
    logic [7:0]        value_reg;
    logic              out_valid_reg;
    logic signed [11:0] gx;
    logic signed [11:0] gy;
    logic signed [12:0] avg;
    logic signed [11:0] lap;
    logic [28:0]       sum64;
    logic [7:0]        res_c;
    logic signed [23:0] sharp_v;

    // Rounds v / 2^sh to nearest with ties to even, then saturates.
    function automatic logic [7:0] rnd_sat(input logic signed [23:0] v, input int sh);
        logic signed [23:0] q;
        logic [23:0]        mask;
        logic [23:0]        r;
        logic [23:0]        half;
        begin
            q    = v >>> sh;
            mask = (24'd1 << sh) - 24'd1;
            r    = v & mask;
            half = 24'd1 << (sh - 1);
            if ((r > half) || ((r == half) && q[0]))
            begin
                q = q + 24'sd1;
            end
            if (q < 0)
            begin
                rnd_sat = 8'd0;
            end
            else if (q > 24'sd255)
            begin
                rnd_sat = 8'd255;
            end
            else
            begin
                rnd_sat = q[7:0];
            end
        end
    endfunction

    // Gradients and kernel sums of the neighbourhood.
    always_comb
    begin
        gx  = 12'(signed'({4'b0, w_reg.p[2]})) + 12'(signed'({3'b0, w_reg.p[5], 1'b0}))
            + 12'(signed'({4'b0, w_reg.p[8]})) - 12'(signed'({4'b0, w_reg.p[0]}))
            - 12'(signed'({3'b0, w_reg.p[3], 1'b0})) - 12'(signed'({4'b0, w_reg.p[6]}));
        gy  = 12'(signed'({4'b0, w_reg.p[6]})) + 12'(signed'({3'b0, w_reg.p[7], 1'b0}))
            + 12'(signed'({4'b0, w_reg.p[8]})) - 12'(signed'({4'b0, w_reg.p[0]}))
            - 12'(signed'({3'b0, w_reg.p[1], 1'b0})) - 12'(signed'({4'b0, w_reg.p[2]}));
        avg = 13'({5'b0, w_reg.p[0]}) + 13'({4'b0, w_reg.p[1], 1'b0}) + 13'({5'b0, w_reg.p[2]})
            + 13'({4'b0, w_reg.p[3], 1'b0}) + 13'({3'b0, w_reg.p[4], 2'b0})
            + 13'({4'b0, w_reg.p[5], 1'b0}) + 13'({5'b0, w_reg.p[6]})
            + 13'({4'b0, w_reg.p[7], 1'b0}) + 13'({5'b0, w_reg.p[8]});
        lap = 12'(signed'({4'b0, w_reg.p[1]})) + 12'(signed'({4'b0, w_reg.p[7]}))
            + 12'(signed'({4'b0, w_reg.p[3]})) + 12'(signed'({4'b0, w_reg.p[5]}))
            - 12'(signed'({2'b0, w_reg.p[4], 2'b0}));
    end

    assign sum64   = {1'b0, sq_x_reg + sq_y_reg, 6'b0} >> 0;
    assign sharp_v = 24'(signed'({8'b0, w_reg.p[4], 8'b0})) - 24'(prod_reg);

    // Result selection.
    always_comb
    begin
        unique case (mode)
            if3_pkg::MODE_AVG:   res_c = rnd_sat(24'(avg_reg), 4);
            if3_pkg::MODE_SHARP: res_c = rnd_sat(sharp_v, 8);
            if3_pkg::MODE_SOBX:  res_c = rnd_sat(24'(gx_reg) + 24'sd512, 2);
            if3_pkg::MODE_SOBY:  res_c = rnd_sat(24'(gy_reg) + 24'sd512, 2);
            if3_pkg::MODE_MAG:
            begin
                res_c = ((root_reg + 15'd16) >> 5) > 15'd255 ? 8'd255
                      : 8'((root_reg + 15'd16) >> 5);
            end
            default:             res_c = 8'd0;
        endcase
    end

    logic [57:0] radicand_reg;
    logic [30:0] rem_next;
    logic [14:0] root_next;

    // Restoring square root step: one result bit per cycle, two radicand bits.
    always_comb
    begin
        rem_next  = {rem_reg[28:0], radicand_reg[57:56]};
        root_next = {root_reg[13:0], 1'b0};
        if (rem_next >= {14'b0, root_reg, 2'b01})
        begin
            rem_next  = rem_next - {14'b0, root_reg, 2'b01};
            root_next = {root_reg[13:0], 1'b1};
        end
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            w_reg         <= '0;
            gx_reg        <= '0;
            gy_reg        <= '0;
            avg_reg       <= '0;
            lap_reg       <= '0;
            prod_reg      <= '0;
            sq_x_reg      <= '0;
            sq_y_reg      <= '0;
            rem_reg       <= '0;
            root_reg      <= '0;
            radicand_reg  <= '0;
            value_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        w_reg     <= in_data;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    gx_reg    <= gx;
                    gy_reg    <= gy;
                    avg_reg   <= avg;
                    lap_reg   <= lap;
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    prod_reg  <= 23'(signed'({1'b0, sharpen_gain})) * 23'(lap_reg);
                    sq_x_reg  <= 22'(gx_reg * gx_reg);
                    sq_y_reg  <= 22'(gy_reg * gy_reg);
                    state_reg <= (mode == if3_pkg::MODE_MAG) ? S_SQRT : S_RES;
                    step_reg  <= '0;
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    radicand_reg <= '0;
                end
                S_SQRT:
                begin
                    if (step_reg == 4'd0 && radicand_reg == '0 && root_reg == '0
                        && rem_reg == '0)
                    begin
                        // The 30-bit radicand sits in the top bits, taken in pairs.
                        radicand_reg <= {1'b0, sum64, 28'b0};
                        step_reg     <= 4'd1;
                    end
                    else
                    begin
                        rem_reg      <= rem_next[28:0];
                        root_reg     <= root_next;
                        radicand_reg <= {radicand_reg[55:0], 2'b0};
                        step_reg     <= step_reg + 4'd1;
                        if (step_reg == 4'd15)
                        begin
                            state_reg <= S_RES;
                        end
                    end
                end
                S_RES:
                begin
                    value_reg     <= res_c;
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign out_row   = w_reg.row;
    assign out_col   = w_reg.col;
    assign last      = w_reg.last;

    `IF3_ASSERT_IMPL(a_out_state, clk, rst_n, out_valid_reg, state_reg == S_OUT)
    `IF3_ASSERT_IMPL(a_sqrt_len, clk, rst_n, state_reg == S_SQRT, step_reg <= 4'd15)
    `IF3_ASSERT_NEVER(a_take_busy, clk, rst_n, in_valid && in_ready && out_valid_reg)

endmodule

// ===== src/image_filter_3x3.sv =====
// ----------------------------------------------------------------------------
// image_filter_3x3
// Streaming 3x3 filter for 8-bit grey frames in raster order.
// ----------------------------------------------------------------------------
// Pixels enter on the pixel/frame_start request channel (valid/ready); each
// interior pixel leaves as one request on value/out_row/out_col/last.
// Border pixels give no result. Configuration is written through cfg_we,
// cfg_index and cfg_data; the user must write it only while the block is
// idle, which the block itself does not enforce: 0 mode, 1 sharpen_gain,
// 2 image_width, 3 image_height. The front takes one pixel at a time:
// accept, registered line buffer read and, for a pixel that completes a
// neighbourhood, hand-over to a four-entry queue, waiting while it is full.
// The back takes one neighbourhood at a time through its MUL, ADD, RES and
// OUT states, in gradient magnitude with SQRT after ADD, where a restoring
// square root takes a load step and then one result bit per cycle over
// fifteen steps; that unit sets the rate in that mode.
// Reset clears the counters, window and queue and loads the register
// defaults; line buffer contents stay undefined until written. When the
// receiver stalls, the result holds, the queue fills and then the input
// request is held off.
// ----------------------------------------------------------------------------
module image_filter_3x3 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        ready,
    input  logic [7:0]  pixel,
    input  logic        frame_start,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  value,
    output logic [11:0] out_row,
    output logic [9:0]  out_col,
    output logic        last
);

    logic [2:0]       mode_reg;
    logic [8:0]       gain_reg;
    logic [10:0]      width_reg;
    logic [11:0]      height_reg;
    logic             f_valid;
    logic             f_ready;
    if3_pkg::window_t f_win;
    logic             b_valid;
    logic             b_ready;
    if3_pkg::window_t b_win;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= if3_pkg::MODE_AVG;
            gain_reg   <= 9'd154;
            width_reg  <= 11'd640;
            height_reg <= 12'd480;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                if3_pkg::REG_MODE:   mode_reg   <= cfg_data[2:0];
                if3_pkg::REG_GAIN:   gain_reg   <= cfg_data[8:0];
                if3_pkg::REG_WIDTH:  width_reg  <= cfg_data[10:0];
                if3_pkg::REG_HEIGHT: height_reg <= cfg_data;
                default:             mode_reg   <= mode_reg;
            endcase
        end
    end

    if3_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel        (pixel),
        .frame_start  (frame_start),
        .valid        (valid),
        .ready        (ready),
        .image_width  (width_reg),
        .image_height (height_reg),
        .win_valid    (f_valid),
        .win          (f_win),
        .win_ready    (f_ready)
    );

    if3_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_win),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_win)
    );

    if3_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (b_valid),
        .in_ready     (b_ready),
        .in_data      (b_win),
        .mode         (mode_reg),
        .sharpen_gain (gain_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .value        (value),
        .out_row      (out_row),
        .out_col      (out_col),
        .last         (last)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_filter_3x3 testbench
// Streams grey frames through the 3x3 filter under every mode, random gains and a
// range of geometries, predicts each interior result in a scoreboard and
// compares it field by field with what the block hands back.
// ----------------------------------------------------------------------------
module tb;

    // Expected results of the filter, predicted from the accepted pixels.
    class filter_scoreboard;
        logic [2:0]  mode_q;
        logic [8:0]  gain_q;
        logic [10:0] width_q;
        logic [11:0] height_q;
        logic [7:0]  line_above[if3_pkg::MaxWidth];
        logic [7:0]  line_two_above[if3_pkg::MaxWidth];
        logic [7:0]  win[6];
        int          col_cnt;
        int          row_cnt;
        logic [30:0] pending[$];

        function new();
            mode_q   = if3_pkg::MODE_AVG;
            gain_q   = 9'd154;
            width_q  = 11'd640;
            height_q = 12'd480;
            foreach (win[i]) win[i] = '0;
            col_cnt = 0;
            row_cnt = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [11:0] data);
            case (idx)
                if3_pkg::REG_MODE:   mode_q   = data[2:0];
                if3_pkg::REG_GAIN:   gain_q   = data[8:0];
                if3_pkg::REG_WIDTH:  width_q  = data[10:0];
                if3_pkg::REG_HEIGHT: height_q = data[11:0];
                default:             mode_q   = mode_q;
            endcase
        endfunction

        // Division by 2^sh, nearest with ties to even.
        function int round_even(int v, int sh);
            int q;
            int r;
            int half;
            q = v >>> sh;
            r = v - (q <<< sh);
            half = 1 << (sh - 1);
            if (r > half || (r == half && q[0]))
                q++;
            return q;
        endfunction

        function int clip8(int v);
            return (v < 0) ? 0 : (v > 255) ? 255 : v;
        endfunction

        function int int_sqrt(int unsigned x);
            int unsigned res;
            int unsigned bitv;
            res = 0;
            bitv = 1 << 30;
            while (bitv > x) bitv >>= 2;
            while (bitv != 0) begin
                if (x >= res + bitv) begin
                    x -= res + bitv;
                    res = (res >> 1) + bitv;
                end
                else
                    res >>= 1;
                bitv >>= 2;
            end
            return res;
        endfunction

        function int filtered(int p[3][3]);
            int gx;
            int gy;
            int s;
            int unsigned m;
            gx = (p[0][2] + 2 * p[1][2] + p[2][2]) - (p[0][0] + 2 * p[1][0] + p[2][0]);
            gy = (p[2][0] + 2 * p[2][1] + p[2][2]) - (p[0][0] + 2 * p[0][1] + p[0][2]);
            case (mode_q)
                if3_pkg::MODE_AVG:
                begin
                    s = p[0][0] + 2 * p[0][1] + p[0][2] + 2 * p[1][0] + 4 * p[1][1]
                        + 2 * p[1][2] + p[2][0] + 2 * p[2][1] + p[2][2];
                    return clip8(round_even(s, 4));
                end
                if3_pkg::MODE_SHARP:
                begin
                    s = p[0][1] + p[2][1] + p[1][0] + p[1][2] - 4 * p[1][1];
                    return clip8(round_even(p[1][1] * 256 - int'(gain_q) * s, 8));
                end
                if3_pkg::MODE_SOBX: return clip8(round_even(gx + 512, 2));
                if3_pkg::MODE_SOBY: return clip8(round_even(gy + 512, 2));
                if3_pkg::MODE_MAG:
                begin
                    m = (int_sqrt((gx * gx + gy * gy) * 64) + 16) >> 5;
                    return (m > 255) ? 255 : m;
                end
                default: return 0;
            endcase
        endfunction

        // Note one accepted pixel and queue the result it completes, if any.
        function void note_pixel(logic [7:0] pix, logic fs);
            int w;
            int h;
            int col;
            int row;
            int p[3][3];
            logic [7:0] top;
            logic [7:0] mid;
            logic [7:0] res;
            logic       lst;
            w = (width_q < 3) ? 3 : (width_q > if3_pkg::MaxWidth) ? if3_pkg::MaxWidth
                                                                   : width_q;
            h = (height_q < 3) ? 3 : height_q;
            if (fs) begin
                col_cnt = 0;
                row_cnt = 0;
            end
            col = (col_cnt >= if3_pkg::MaxWidth) ? 0 : col_cnt;
            row = row_cnt;
            top = line_two_above[col];
            mid = line_above[col];
            if (row >= 2 && col >= 2) begin
                p[0][0] = win[3]; p[1][0] = win[4]; p[2][0] = win[5];
                p[0][1] = win[0]; p[1][1] = win[1]; p[2][1] = win[2];
                p[0][2] = top;    p[1][2] = mid;    p[2][2] = pix;
                res = 8'(filtered(p));
                lst = (row + 1 >= h && col + 1 >= w);
                pending.push_back({res, 12'(row - 1), 10'(col - 1), lst});
            end
            line_two_above[col] = mid;
            line_above[col] = pix;
            win[3] = win[0]; win[4] = win[1]; win[5] = win[2];
            win[0] = top;    win[1] = mid;    win[2] = pix;
            if (col + 1 >= w) begin
                col_cnt = 0;
                row_cnt = (row + 1 >= h) ? 0 : row + 1;
            end
            else begin
                col_cnt = col + 1;
                row_cnt = row;
            end
        endfunction

        // Compare one result with the oldest expectation; empty string if it agrees.
        function string check_result(logic [7:0] v, logic [11:0] r, logic [9:0] c, logic l);
            logic [30:0] e;
            if (pending.size() == 0)
                return $sformatf("unexpected result value=%0d row=%0d col=%0d", v, r, c);
            e = pending.pop_front();
            if (e[30:23] !== v || e[22:11] !== r || e[10:1] !== c || e[0] !== l)
                return $sformatf({"row %0d col %0d: got value=%0d row=%0d col=%0d ",
                                  "last=%0b, want value=%0d last=%0b"},
                                 e[22:11], e[10:1], v, r, c, l, e[30:23], e[0]);
            return "";
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        valid;
    logic        ready;
    logic [7:0]  pixel;
    logic        frame_start;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [11:0] cfg_data;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  value;
    logic [11:0] out_row;
    logic [9:0]  out_col;
    logic        last;

    filter_scoreboard sb = new();
    int  mismatches = 0;
    int  items_sent = 0;
    bit  jitter_on  = 1'b1;

    image_filter_3x3 u_dut (
        .clk(clk), .rst_n(rst_n),
        .valid(valid), .ready(ready), .pixel(pixel), .frame_start(frame_start),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .out_valid(out_valid), .out_ready(out_ready),
        .value(value), .out_row(out_row), .out_col(out_col), .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(string msg);
        $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    // Both monitors sample at the edge where a request is accepted.
    always @(posedge clk)
    begin
        string msg;
        if (rst_n && valid && ready)
            sb.note_pixel(pixel, frame_start);
        if (rst_n && out_valid && out_ready) begin
            msg = sb.check_result(value, out_row, out_col, last);
            if (msg != "")
                report_mismatch(msg);
        end
    end

    // Receiver stalls at random while jitter is enabled.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !(jitter_on && $urandom_range(0, 99) < 19);
    end

    task automatic write_reg(logic [1:0] idx, logic [11:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.set_reg(idx, data);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(logic [2:0] m, logic [8:0] g, logic [10:0] w, logic [11:0] h);
        write_reg(if3_pkg::REG_MODE, 12'(m));
        write_reg(if3_pkg::REG_GAIN, 12'(g));
        write_reg(if3_pkg::REG_WIDTH, 12'(w));
        write_reg(if3_pkg::REG_HEIGHT, h);
    endtask

    // One input request: optional gap, then hold valid until accepted.
    task automatic send_pixel(logic [7:0] p, logic fs);
        if (jitter_on && $urandom_range(0, 99) < 19) begin
            valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        valid       <= 1'b1;
        pixel       <= p;
        frame_start <= fs;
        do @(posedge clk); while (!ready);
        items_sent++;
    endtask

    // Let every expected result drain, plus the magnitude-mode latency.
    task automatic wait_idle();
        @(posedge clk);
        valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic send_frame(int n, bit rand_pix, logic [7:0] fixed_pix, bit first_fs);
        for (int i = 0; i < n; i++)
            send_pixel(rand_pix ? 8'($urandom) : fixed_pix, first_fs && i == 0);
    endtask

    int w_eff;
    int h_eff;
    int n_pix;
    logic [10:0] w_cfg;
    logic [11:0] h_cfg;
    bit fs_next;

    initial
    begin
        rst_n = 1'b0;
        valid = 1'b0;
        pixel = '0;
        frame_start = 1'b0;
        cfg_we = 1'b0;
        cfg_index = if3_pkg::REG_MODE;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: register defaults, then small frames in each mode, two for sharpen.
        send_frame(4, 1'b1, 8'd0, 1'b1);
        wait_idle();
        configure(if3_pkg::MODE_AVG, 9'd0, 11'd3, 12'd3);
        send_frame(9, 1'b0, 8'd255, 1'b1);
        wait_idle();
        write_reg(if3_pkg::REG_MODE, 12'(if3_pkg::MODE_SHARP));
        write_reg(if3_pkg::REG_GAIN, 12'd256);
        for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 8'd0 : 8'd255, i == 0);
        wait_idle();
        write_reg(if3_pkg::REG_GAIN, 12'd511);
        for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 8'd255 : 8'd0, i == 0);
        wait_idle();
        for (int m = int'(if3_pkg::MODE_SOBX); m <= 7; m++) begin
            write_reg(if3_pkg::REG_MODE, 12'(m));
            for (int i = 0; i < 9; i++) send_pixel((i % 3 == 2) ? 8'd255 : 8'd0, i == 0);
            wait_idle();
        end
        // Width and height below the minimum act as three.
        configure(if3_pkg::MODE_SOBY, 9'd154, 11'd0, 12'd0);
        for (int i = 0; i < 9; i++) send_pixel((i >= 6) ? 8'd255 : 8'd0, i == 0);
        wait_idle();

        // Random geometry and settings; one calm stretch without any gaps.
        fs_next = 1'b1;
        while (items_sent < 1000) begin
            jitter_on = !(items_sent > 400 && items_sent < 700);
            w_cfg = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 2))
                                                : 11'($urandom_range(3, 10));
            h_cfg = 12'($urandom_range(0, 6));
            configure(3'($urandom_range(0, 7)), 9'($urandom_range(0, 511)), w_cfg, h_cfg);
            w_eff = (w_cfg < 3) ? 3 : int'(w_cfg);
            h_eff = (h_cfg < 3) ? 3 : int'(h_cfg);
            fs_next = 1'b1;
            repeat ($urandom_range(1, 3)) begin
                n_pix = w_eff * h_eff;
                // A broken frame stops early; the next one then restarts explicitly.
                if ($urandom_range(0, 9) == 0)
                    n_pix = $urandom_range(1, n_pix - 1);
                send_frame(n_pix, 1'b1, 8'd0, fs_next);
                fs_next = (n_pix != w_eff * h_eff) || $urandom_range(0, 1);
            end
            wait_idle();
        end

        // Tallest frame, only its first rows.
        jitter_on = 1'b1;
        configure(if3_pkg::MODE_AVG, 9'd154, 11'd3, 12'd4095);
        send_frame(60, 1'b1, 8'd0, 1'b1);
        wait_idle();

        if (mismatches == 0 && sb.pending.size() == 0)
            $display("image_filter_3x3 regression: pass");
        else
            $display("image_filter_3x3 regression: fail");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #20ms;
        $display("image_filter_3x3 regression: fail");
        $finish;
    end

endmodule
